>>> src/chi_pkg.sv
// Package with item types and codes for the chained hash index.
package chi_pkg;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_PRESENT   = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [63:0] key;
    logic [63:0] entry_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] found_data;
    logic [11:0] node_index;
  } out_item_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_HEAD_RD,
    S_HEAD_WT,
    S_NODE_RD,
    S_NODE_WT,
    S_NODE_CMP,
    S_PAY_RD,
    S_PAY_WT,
    S_DECIDE,
    S_OUT
  } state_t;

endpackage

>>> src/chained_hash_index.sv
// Top level of the chained hash index: sequencer, remainder unit and memories.
// The bucket remainder is found by bit-serial division of the key's low 32 bits; a miss
// walks all k chain nodes, while a hit ends the walk at node k.
// One item is processed at a time; the result register frees the input only once taken.
// After reset a clearing pass zeroes the bucket heads; no item is accepted meanwhile,
// configuration writes are taken as always.
module chained_hash_index #(
  parameter int MAX_BUCKETS = 1024,
  parameter int POOL_NODES  = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  chi_pkg::in_item_t    in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output chi_pkg::out_item_t   out_item,
  input  logic                 cfg_we,
  input  logic [10:0]          cfg_data
);

  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int NW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int LW = $clog2(POOL_NODES + 1);
  localparam int RW = 18;

  chi_pkg::state_t state, state_next;

  logic [10:0]   bucket_count;
  logic [RW-1:0] divisor;
  logic [RW-1:0] rem;
  logic [31:0]   quo;
  logic [5:0]    mcnt;
  logic [BW-1:0] clr_idx;
  logic [BW-1:0] bucket;
  logic [LW-1:0] link, tail, next_free;
  logic [NW-1:0] hit;
  logic          present;
  logic          op;
  logic [63:0]   key_r, data_r, found_r;

  logic [LW-1:0] head_mem [MAX_BUCKETS];
  logic [63:0]   key_mem  [POOL_NODES];
  logic [63:0]   pay_mem  [POOL_NODES];
  logic [LW-1:0] next_mem [POOL_NODES];
  logic [LW-1:0] head_q, next_q;
  logic [63:0]   key_q, pay_q;

  logic [RW-1:0] rem_sh, rem_sub;
  logic          accept, link_ok, do_ins;
  logic [NW-1:0] link_node;

  always_comb begin
    if (bucket_count == 11'd0) begin
      divisor = RW'(1);
    end else if (32'(bucket_count) > 32'(MAX_BUCKETS)) begin
      divisor = RW'(MAX_BUCKETS);
    end else begin
      divisor = RW'(bucket_count);
    end
  end

  assign accept    = in_valid && in_ready;
  assign link_node = NW'(link - LW'(1));
  assign link_ok   = (link != '0) && (32'(link) <= 32'(POOL_NODES));
  assign rem_sh    = {rem[RW-2:0], quo[31]};
  assign rem_sub   = rem_sh - divisor;
  assign do_ins    = (state == chi_pkg::S_DECIDE) && op == chi_pkg::OP_INSERT && !present
                     && 32'(next_free) < 32'(POOL_NODES);

  always_comb begin
    state_next = state;
    unique case (state)
      chi_pkg::S_CLEAR:    if (32'(clr_idx) == MAX_BUCKETS - 1) state_next = chi_pkg::S_IDLE;
      chi_pkg::S_IDLE:     if (in_valid) state_next = chi_pkg::S_MOD;
      chi_pkg::S_MOD:      if (mcnt == 6'd31) state_next = chi_pkg::S_HEAD_RD;
      chi_pkg::S_HEAD_RD:  state_next = chi_pkg::S_HEAD_WT;
      chi_pkg::S_HEAD_WT:  state_next = chi_pkg::S_NODE_RD;
      chi_pkg::S_NODE_RD:  state_next = link_ok ? chi_pkg::S_NODE_WT : chi_pkg::S_DECIDE;
      chi_pkg::S_NODE_WT:  state_next = chi_pkg::S_NODE_CMP;
      chi_pkg::S_NODE_CMP: state_next = (key_q == key_r) ? chi_pkg::S_PAY_RD
                                                          : chi_pkg::S_NODE_RD;
      chi_pkg::S_PAY_RD:   state_next = chi_pkg::S_PAY_WT;
      chi_pkg::S_PAY_WT:   state_next = chi_pkg::S_DECIDE;
      chi_pkg::S_DECIDE:   state_next = chi_pkg::S_OUT;
      chi_pkg::S_OUT:      if (out_ready) state_next = chi_pkg::S_IDLE;
      default:             state_next = chi_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == chi_pkg::S_IDLE);
    out_valid = (state == chi_pkg::S_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= chi_pkg::S_CLEAR;
      bucket_count <= 11'd1024;
      clr_idx      <= '0;
      next_free    <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) bucket_count <= cfg_data;
      if (state == chi_pkg::S_CLEAR) clr_idx <= clr_idx + BW'(1);
      if (do_ins) next_free <= next_free + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= in_item.operation;
      key_r  <= in_item.key;
      data_r <= in_item.entry_data;
      quo    <= in_item.key[31:0];
      rem    <= '0;
      mcnt   <= '0;
    end
    if (state == chi_pkg::S_MOD) begin
      mcnt <= mcnt + 6'd1;
      if (rem_sh >= divisor) begin
        rem <= rem_sub;
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[30:0], 1'b0};
      end
    end
    if (state == chi_pkg::S_HEAD_RD) bucket <= BW'(rem);
    if (state == chi_pkg::S_HEAD_WT) begin
      link    <= head_q;
      tail    <= '0;
      present <= 1'b0;
      found_r <= '0;
    end
    if (state == chi_pkg::S_NODE_CMP) begin
      if (key_q == key_r) begin
        present <= 1'b1;
        hit     <= link_node;
      end else begin
        tail <= link;
        link <= next_q;
      end
    end
    if (state == chi_pkg::S_PAY_WT) found_r <= pay_q;
    if (state == chi_pkg::S_DECIDE) begin
      out_item.found_data <= '0;
      out_item.node_index <= '0;
      if (op == chi_pkg::OP_LOOKUP) begin
        if (present) begin
          out_item.status     <= chi_pkg::ST_OK;
          out_item.found_data <= found_r;
          out_item.node_index <= 12'(hit);
        end else begin
          out_item.status <= chi_pkg::ST_NOT_FOUND;
        end
      end else if (present) begin
        out_item.status     <= chi_pkg::ST_PRESENT;
        out_item.node_index <= 12'(hit);
      end else if (!do_ins) begin
        out_item.status <= chi_pkg::ST_FULL;
      end else begin
        out_item.status     <= chi_pkg::ST_OK;
        out_item.node_index <= 12'(next_free);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == chi_pkg::S_CLEAR) begin
      head_mem[clr_idx] <= '0;
    end else if (do_ins && tail == '0) begin
      head_mem[bucket] <= next_free + LW'(1);
    end
    head_q <= head_mem[BW'(rem)];
  end

  always_ff @(posedge clk) begin
    if (do_ins) begin
      key_mem[NW'(next_free)] <= key_r;
      pay_mem[NW'(next_free)] <= data_r;
    end
    key_q <= key_mem[link_node];
    pay_q <= pay_mem[hit];
  end

  // The free node is not linked yet, so its end-of-chain mark is set ahead of the insert.
  always_ff @(posedge clk) begin
    if (do_ins && tail != '0) begin
      next_mem[NW'(tail - LW'(1))] <= next_free + LW'(1);
    end else if (state == chi_pkg::S_MOD && 32'(next_free) < 32'(POOL_NODES)) begin
      next_mem[NW'(next_free)] <= '0;
    end
    next_q <= next_mem[link_node];
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == chi_pkg::S_MOD)
    else $error("Item accepted outside idle.");
  a_one_state: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("Input ready while a result is pending.");
  a_free_grows: assert property (@(posedge clk) disable iff (rst)
    !do_ins |=> $stable(next_free))
    else $error("Free count moved without an insert.");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == chi_pkg::S_HEAD_RD |-> rem < divisor)
    else $error("Bucket remainder out of range.");
`endif

endmodule

>>> verif/tb_chained_hash_index.sv
// Testbench for the chained hash index with lookups and inserts checked against a table model.
module tb_chained_hash_index;

  localparam int NUM_BUCKETS_MAX = 1024;
  localparam int NUM_NODES = 4096;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  chi_pkg::in_item_t in_item;
  logic out_valid;
  logic out_ready;
  chi_pkg::out_item_t out_item;
  logic cfg_we;
  logic [10:0] cfg_data;

  chained_hash_index uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  // Table mirror.
  int unsigned mdl_bucket_count;
  int unsigned mdl_head [NUM_BUCKETS_MAX];
  logic [63:0] mdl_key [NUM_NODES];
  logic [63:0] mdl_payload [NUM_NODES];
  int unsigned mdl_next [NUM_NODES];
  int unsigned mdl_used;
  logic [63:0] stored_keys [$];

  chi_pkg::out_item_t expected_results [$];
  int fail_count;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic chi_pkg::out_item_t lookup_or_insert(chi_pkg::in_item_t it);
    chi_pkg::out_item_t res;
    int unsigned eff;
    int unsigned b;
    int unsigned link;
    int unsigned tail;
    int unsigned steps;
    int unsigned hit;
    bit present;
    eff = (mdl_bucket_count == 0) ? 1 :
          (mdl_bucket_count > NUM_BUCKETS_MAX) ? NUM_BUCKETS_MAX : mdl_bucket_count;
    b = it.key[31:0] % eff;
    link = mdl_head[b];
    tail = 0;
    steps = 0;
    hit = 0;
    present = 1'b0;
    while (link != 0 && steps < NUM_NODES && !present) begin
      if (mdl_key[link - 1] == it.key) begin
        present = 1'b1;
        hit = link - 1;
      end else begin
        tail = link;
        link = mdl_next[link - 1];
        steps++;
      end
    end
    res = '0;
    if (it.operation == chi_pkg::OP_LOOKUP) begin
      if (present) begin
        res.status = chi_pkg::ST_OK;
        res.found_data = mdl_payload[hit];
        res.node_index = hit[11:0];
      end else begin
        res.status = chi_pkg::ST_NOT_FOUND;
      end
    end else if (present) begin
      res.status = chi_pkg::ST_PRESENT;
      res.node_index = hit[11:0];
    end else if (mdl_used >= NUM_NODES) begin
      res.status = chi_pkg::ST_FULL;
    end else begin
      mdl_key[mdl_used] = it.key;
      mdl_payload[mdl_used] = it.entry_data;
      mdl_next[mdl_used] = 0;
      if (tail != 0) mdl_next[tail - 1] = mdl_used + 1;
      else mdl_head[b] = mdl_used + 1;
      res.status = chi_pkg::ST_OK;
      res.node_index = mdl_used[11:0];
      mdl_used++;
      stored_keys.push_back(it.key);
    end
    return res;
  endfunction

  task automatic send_item(logic op, logic [63:0] key, logic [63:0] data);
    chi_pkg::in_item_t it;
    int gap;
    it.operation = op;
    it.key = key;
    it.entry_data = data;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(lookup_or_insert(it));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_buckets(logic [10:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    mdl_bucket_count = value;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_key();
    int r;
    logic [63:0] k;
    r = $urandom_range(99);
    if (stored_keys.size() == 0 || r < 40) return rand64();
    k = stored_keys[$urandom_range(stored_keys.size() - 1)];
    if (r < 75) return k;
    if (r < 90) return {$urandom, k[31:0]};
    return 64'($urandom_range(50));
  endfunction

  // Checks each result and drives the receiver side.
  always @(posedge clk) begin
    chi_pkg::out_item_t exp_res;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected item: status %0d", out_item.status);
        fail_count++;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_item.status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, out_item.status);
          fail_count++;
        end
        if (out_item.found_data !== exp_res.found_data) begin
          $error("found_data: expected %h, got %h", exp_res.found_data, out_item.found_data);
          fail_count++;
        end
        if (out_item.node_index !== exp_res.node_index) begin
          $error("node_index: expected %0d, got %0d", exp_res.node_index, out_item.node_index);
          fail_count++;
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic test_empty_table();
    send_item(chi_pkg::OP_LOOKUP, 64'h0, 64'h0);
    send_item(chi_pkg::OP_LOOKUP, '1, '1);
    send_item(chi_pkg::OP_LOOKUP, 64'h8000_0000_0000_03FF, 64'h0);
  endtask

  task automatic test_insert_and_chain();
    send_item(chi_pkg::OP_INSERT, 64'h0, '1);
    send_item(chi_pkg::OP_INSERT, '1, 64'h0);
    send_item(chi_pkg::OP_LOOKUP, 64'h0, 64'h0);
    send_item(chi_pkg::OP_LOOKUP, '1, 64'h0);
    send_item(chi_pkg::OP_INSERT, 64'h0, 64'h1234);
    send_item(chi_pkg::OP_INSERT, 64'hFFFF_FFFF_0000_0000, 64'hA5A5_A5A5_5A5A_5A5A);
    send_item(chi_pkg::OP_INSERT, 64'h0000_0001_0000_0400, 64'h5A5A_5A5A_A5A5_A5A5);
    send_item(chi_pkg::OP_LOOKUP, 64'hFFFF_FFFF_0000_0000, 64'h0);
    send_item(chi_pkg::OP_LOOKUP, 64'h0000_0001_0000_0400, 64'h0);
    send_item(chi_pkg::OP_LOOKUP, 64'h0000_0002_0000_0000, 64'h0);
  endtask

  task automatic test_bucket_settings();
    set_buckets(11'd0);
    send_item(chi_pkg::OP_LOOKUP, 64'h0, 64'h0);
    send_item(chi_pkg::OP_INSERT, 64'h0000_0000_0000_0007, 64'h77);
    set_buckets(11'd2047);
    send_item(chi_pkg::OP_LOOKUP, '1, 64'h0);
    send_item(chi_pkg::OP_INSERT, 64'h0000_0000_0000_07FF, 64'h99);
    set_buckets(11'd1);
    send_item(chi_pkg::OP_LOOKUP, 64'h0000_0000_0000_0007, 64'h0);
    send_item(chi_pkg::OP_LOOKUP, 64'h0000_0000_0000_07FF, 64'h0);
    set_buckets(11'd1024);
    send_item(chi_pkg::OP_LOOKUP, 64'h0000_0000_0000_07FF, 64'h0);
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    repeat (6) send_item(1'($urandom_range(1)), pick_key(), rand64());
  endtask

  task automatic test_random(int count, logic [10:0] buckets);
    set_buckets(buckets);
    repeat (count) send_item(1'($urandom_range(1)), pick_key(), rand64());
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    fail_count = 0;
    hold_cycles = 0;
    send_idle_pct = 29;
    recv_idle_pct = 46;
    mdl_bucket_count = 1024;
    mdl_used = 0;
    foreach (mdl_head[i]) mdl_head[i] = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_insert_and_chain();
    test_bucket_settings();
    test_backpressure();
    test_random(300, 11'd1024);
    test_random(150, 11'd37);
    test_random(150, 11'd500);
    send_idle_pct = 46;
    recv_idle_pct = 29;
    test_random(300, 11'd1024);
    test_random(100, 11'd2);
    test_random(200, 11'd1023);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(350, 11'd1024);
    test_random(100, 11'd64);
    test_random(150, 11'd1024);
    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(4 * 3000000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
